@@ src/ledblk_pkg.sv @@
// Shared types and constants for the LED duty and error code blinker.
package ledblk_pkg;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_DUTY     = 2'd0;
  localparam logic [1:0] REG_CYCLE    = 2'd1;
  localparam logic [1:0] REG_IDENTIFY = 2'd2;

  // Register reset values
  localparam logic [6:0]  DUTY_RST  = 7'd10;
  localparam logic [15:0] CYCLE_RST = 16'd500;

  // Full duty in percent
  localparam logic [6:0] DUTY_FULL = 7'd100;

  // Fixed timings in milliseconds
  localparam logic [15:0] IDENT_MS = 16'd100;
  localparam logic [10:0] LEAD_MS  = 11'd500;
  localparam logic [10:0] BLINK_MS = 11'd125;
  localparam logic [10:0] GAP_MS   = 11'd2000;

  // Divide by 100: floor(2^23 / 100), quotient low by at most one
  localparam int unsigned RECIP_SHIFT = 23;
  localparam logic [16:0] RECIP_100   = 17'd83886;

  // Cycles from a register write until the phase lengths are settled
  localparam logic [1:0] LEN_LAT = 2'd3;

  typedef struct packed {
    logic [6:0]  duty;
    logic [15:0] cycle;
    logic        identify;
  } cfg_t;

  typedef struct packed {
    logic [15:0] on_len;
    logic [15:0] off_len;
  } len_t;

  typedef struct packed {
    logic       action;
    logic [3:0] error_code;
    logic [7:0] repeat_count;
  } item_t;

  typedef struct packed {
    logic led_on;
    logic code_busy;
  } res_t;

endpackage

@@ src/ledblk_len_calc.sv @@
// Phase length pipeline: cycle * duty / 100 for the on phase and cycle * (100 - duty) / 100 for the off phase.
module ledblk_len_calc (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  ledblk_pkg::cfg_t    cfg,
  output ledblk_pkg::len_t    len,
  output logic                busy
);

  logic [6:0]  duty_on;
  logic [6:0]  duty_off;
  logic [22:0] prod_on_r;
  logic [22:0] prod_off_r;
  logic [22:0] x_on_r;
  logic [22:0] x_off_r;
  logic [39:0] rq_on;
  logic [39:0] rq_off;
  logic [15:0] q0_on_r;
  logic [15:0] q0_off_r;
  logic [23:0] rem_on;
  logic [23:0] rem_off;
  logic [15:0] on_len_r;
  logic [15:0] off_len_r;
  logic [1:0]  cnt_r;
  logic [1:0]  cnt_nxt;

  // Clamp duty to full scale and split into on and off shares
  assign duty_on  = (cfg.duty > ledblk_pkg::DUTY_FULL) ? ledblk_pkg::DUTY_FULL : cfg.duty;
  assign duty_off = ledblk_pkg::DUTY_FULL - duty_on;

  // Stage 1: scale the cycle by each share
  always_ff @(posedge clk) begin
    prod_on_r  <= 23'(cfg.cycle) * 23'(duty_on);
    prod_off_r <= 23'(cfg.cycle) * 23'(duty_off);
  end

  // Stage 2: estimate quotient by reciprocal multiply
  assign rq_on  = 40'(prod_on_r) * 40'(ledblk_pkg::RECIP_100);
  assign rq_off = 40'(prod_off_r) * 40'(ledblk_pkg::RECIP_100);

  always_ff @(posedge clk) begin
    x_on_r   <= prod_on_r;
    x_off_r  <= prod_off_r;
    q0_on_r  <= rq_on[ledblk_pkg::RECIP_SHIFT +: 16];
    q0_off_r <= rq_off[ledblk_pkg::RECIP_SHIFT +: 16];
  end

  // Stage 3: fix up the estimate with one compare
  assign rem_on  = 24'(x_on_r) - 24'(q0_on_r) * 24'(ledblk_pkg::DUTY_FULL);
  assign rem_off = 24'(x_off_r) - 24'(q0_off_r) * 24'(ledblk_pkg::DUTY_FULL);

  always_ff @(posedge clk) begin
    on_len_r  <= q0_on_r + 16'(rem_on >= 24'(ledblk_pkg::DUTY_FULL));
    off_len_r <= q0_off_r + 16'(rem_off >= 24'(ledblk_pkg::DUTY_FULL));
  end

  assign len.on_len  = on_len_r;
  assign len.off_len = off_len_r;

  // Count down until the pipeline holds lengths for the current registers
  always_comb begin
    cnt_nxt = cnt_r;
    if (start) begin
      cnt_nxt = ledblk_pkg::LEN_LAT;
    end else if (cnt_r != 2'd0) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= ledblk_pkg::LEN_LAT;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  assign busy = (cnt_r != 2'd0);

endmodule

@@ src/ledblk_core.sv @@
// Blink state: normal duty blink, identify blink and error code player.
module ledblk_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  ledblk_pkg::item_t   item,
  input  ledblk_pkg::cfg_t    cfg,
  input  ledblk_pkg::len_t    len,
  output ledblk_pkg::res_t    res
);

  localparam logic [1:0] ST_LEAD  = 2'd0;
  localparam logic [1:0] ST_ON    = 2'd1;
  localparam logic [1:0] ST_OFF   = 2'd2;
  localparam logic [1:0] ST_GAP   = 2'd3;

  logic        led_r,    led_nxt;
  logic [15:0] phase_r,  phase_nxt;
  logic        act_r,    act_nxt;
  logic [1:0]  stage_r,  stage_nxt;
  logic [3:0]  blinks_r, blinks_nxt;
  logic [3:0]  left_r,   left_nxt;
  logic [7:0]  reps_r,   reps_nxt;
  logic [10:0] ctim_r,   ctim_nxt;
  logic        grp_go;
  logic        duty_zero;
  logic        duty_full;
  logic [15:0] plen;

  assign duty_zero = (cfg.duty == 7'd0);
  assign duty_full = (cfg.duty >= ledblk_pkg::DUTY_FULL);

  always_comb begin
    led_nxt    = led_r;
    phase_nxt  = phase_r;
    act_nxt    = act_r;
    stage_nxt  = stage_r;
    blinks_nxt = blinks_r;
    left_nxt   = left_r;
    reps_nxt   = reps_r;
    ctim_nxt   = ctim_r;
    grp_go     = 1'b0;
    plen       = phase_r;

    if (item.action) begin
      // Start: load the lead pause with the LED off
      act_nxt    = 1'b1;
      stage_nxt  = ST_LEAD;
      blinks_nxt = item.error_code;
      left_nxt   = 4'd0;
      reps_nxt   = item.repeat_count;
      ctim_nxt   = ledblk_pkg::LEAD_MS;
      led_nxt    = 1'b0;
    end else if (act_r) begin
      // Advance the error code sequence
      if (ctim_r > 11'd1) begin
        ctim_nxt = ctim_r - 11'd1;
      end else begin
        unique case (stage_r)
          ST_LEAD: begin
            grp_go = 1'b1;
          end
          ST_ON: begin
            led_nxt   = 1'b0;
            stage_nxt = ST_OFF;
            ctim_nxt  = ledblk_pkg::BLINK_MS;
          end
          ST_OFF: begin
            if (left_r != 4'd0) begin
              left_nxt = left_r - 4'd1;
            end
            if (left_nxt != 4'd0) begin
              led_nxt   = 1'b1;
              stage_nxt = ST_ON;
              ctim_nxt  = ledblk_pkg::BLINK_MS;
            end else begin
              stage_nxt = ST_GAP;
              ctim_nxt  = ledblk_pkg::GAP_MS;
            end
          end
          default: begin
            if (reps_r != 8'd0) begin
              reps_nxt = reps_r - 8'd1;
            end
            grp_go = 1'b1;
          end
        endcase
        // Open the next blink group or a bare gap, or finish the sequence
        if (grp_go) begin
          priority if (reps_nxt == 8'd0) begin
            act_nxt   = 1'b0;
            stage_nxt = ST_LEAD;
            ctim_nxt  = 11'd0;
            led_nxt   = 1'b0;
            phase_nxt = 16'd0;
          end else if (blinks_r != 4'd0) begin
            stage_nxt = ST_ON;
            left_nxt  = blinks_r;
            led_nxt   = 1'b1;
            ctim_nxt  = ledblk_pkg::BLINK_MS;
          end else begin
            stage_nxt = ST_GAP;
            led_nxt   = 1'b0;
            ctim_nxt  = ledblk_pkg::GAP_MS;
          end
        end
      end
    end else if (phase_r <= 16'd1) begin
      // Switch the normal blink phase
      if (!led_r) begin
        priority if (cfg.identify) begin
          led_nxt = 1'b1;
          plen    = ledblk_pkg::IDENT_MS;
        end else if (duty_zero) begin
          plen = cfg.cycle;
        end else if (duty_full) begin
          led_nxt = 1'b1;
          plen    = cfg.cycle;
        end else begin
          led_nxt = 1'b1;
          plen    = len.on_len;
        end
      end else begin
        priority if (cfg.identify) begin
          led_nxt = 1'b0;
          plen    = ledblk_pkg::IDENT_MS;
        end else if (duty_full) begin
          plen = cfg.cycle;
        end else if (duty_zero) begin
          led_nxt = 1'b0;
          plen    = cfg.cycle;
        end else begin
          led_nxt = 1'b0;
          plen    = len.off_len;
        end
      end
      phase_nxt = (plen == 16'd0) ? 16'd1 : plen;
    end else begin
      phase_nxt = phase_r - 16'd1;
    end
  end

  // Hold state between words
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      led_r    <= 1'b0;
      phase_r  <= 16'd0;
      act_r    <= 1'b0;
      stage_r  <= ST_LEAD;
      blinks_r <= 4'd0;
      left_r   <= 4'd0;
      reps_r   <= 8'd0;
      ctim_r   <= 11'd0;
    end else if (fire) begin
      led_r    <= led_nxt;
      phase_r  <= phase_nxt;
      act_r    <= act_nxt;
      stage_r  <= stage_nxt;
      blinks_r <= blinks_nxt;
      left_r   <= left_nxt;
      reps_r   <= reps_nxt;
      ctim_r   <= ctim_nxt;
    end
  end

  assign res.led_on    = led_nxt;
  assign res.code_busy = act_nxt;

endmodule

@@ src/led_duty_and_error_code_blinker.sv @@
// Top level of the LED duty and error code blinker.
// Each input word is either a 1 ms tick or the start of an error code
// sequence, and each gives one output word with the LED level and the
// code-busy flag. Words flow at one per clock while in_stall and out_stall
// stay low: a word is held in the input register, the blink state updates as
// it moves to the output register, and a new word is taken while a result
// waits. After reset and after each register write, in_stall stays high
// while the three-stage multiply pipeline recomputes the on and off phase
// lengths. Registers: 0 duty percent, 1 cycle length in ms, 2 identify.
module led_duty_and_error_code_blinker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_action,
  input  logic [3:0]  in_error_code,
  input  logic [7:0]  in_repeat_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_led_on,
  output logic        out_code_busy,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  ledblk_pkg::cfg_t  cfg_r;
  ledblk_pkg::len_t  len;
  ledblk_pkg::item_t item_r;
  ledblk_pkg::res_t  res;
  ledblk_pkg::res_t  res_r;
  logic              cfg_wr;
  logic              calc_busy;
  logic              in_vld_r;
  logic              in_take;
  logic              fire;
  logic              out_vld_r;

  // Configuration registers
  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.duty     <= ledblk_pkg::DUTY_RST;
      cfg_r.cycle    <= ledblk_pkg::CYCLE_RST;
      cfg_r.identify <= 1'b0;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        ledblk_pkg::REG_DUTY:     cfg_r.duty     <= cfg_wdata[6:0];
        ledblk_pkg::REG_CYCLE:    cfg_r.cycle    <= cfg_wdata;
        ledblk_pkg::REG_IDENTIFY: cfg_r.identify <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  ledblk_len_calc u_len (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cfg_wr),
    .cfg   (cfg_r),
    .len   (len),
    .busy  (calc_busy)
  );

  // Move a word from the input register when the output register frees up
  assign fire     = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = calc_busy || (in_vld_r && !fire);
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      item_r.action       <= in_action;
      item_r.error_code   <= in_error_code;
      item_r.repeat_count <= in_repeat_count;
    end
  end

  ledblk_core u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (fire),
    .item  (item_r),
    .cfg   (cfg_r),
    .len   (len),
    .res   (res)
  );

  // Output register: hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (fire) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      res_r <= res;
    end
  end

  assign out_valid     = out_vld_r;
  assign out_led_on    = res_r.led_on;
  assign out_code_busy = res_r.code_busy;

endmodule

@@ tb/ledblk_checker.sv @@
// Checker for the LED blinker: shadows the registers, predicts each result word and compares.
`timescale 1ns / 1ps

package ledblk_tb_pkg;
  // Kinds of input word
  typedef enum logic {ACT_TICK = 1'b0, ACT_START = 1'b1} action_e;
endpackage

module ledblk_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_action,
  input  logic [3:0]  in_error_code,
  input  logic [7:0]  in_repeat_count,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic        out_led_on,
  input  logic        out_code_busy,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  output int          open_words,
  output int          mismatches
);

  // Error code player stages
  typedef enum logic [1:0] {ST_LEAD, ST_ON, ST_OFF, ST_GAP} code_stage_e;

  localparam int MAX_LINES = 100;

  ledblk_pkg::cfg_t regs;
  logic             lit;
  logic [15:0]      phase_left;
  logic             playing;
  code_stage_e      stage;
  logic [3:0]       group_blinks;
  logic [3:0]       blinks_to_go;
  logic [7:0]       groups_to_go;
  logic [10:0]      stage_left;

  ledblk_pkg::res_t  expected_led_q[$];
  ledblk_pkg::item_t seen;
  ledblk_pkg::res_t  want;
  int                words_out;

  // Print one line per mismatch (bounded) and count it
  task automatic report(input string what);
    mismatches++;
    if (mismatches <= MAX_LINES) $display("mismatch at %0t ns: %s", $time, what);
  endtask

  // Start a blink group, a bare gap, or end the sequence when no groups remain
  function automatic void open_group();
    if (groups_to_go == 0) begin
      playing    = 1'b0;
      stage      = ST_LEAD;
      stage_left = '0;
      lit        = 1'b0;
      phase_left = '0;
    end else if (group_blinks != 0) begin
      stage        = ST_ON;
      blinks_to_go = group_blinks;
      lit          = 1'b1;
      stage_left   = ledblk_pkg::BLINK_MS;
    end else begin
      stage      = ST_GAP;
      lit        = 1'b0;
      stage_left = ledblk_pkg::GAP_MS;
    end
  endfunction

  // Advance the LED state by one input word and return the result it gives
  function automatic ledblk_pkg::res_t predict_led(input ledblk_pkg::item_t w);
    ledblk_pkg::res_t r;
    int unsigned      pct;
    int unsigned      span;
    int unsigned      len;
    if (w.action == ledblk_tb_pkg::ACT_START) begin
      playing      = 1'b1;
      stage        = ST_LEAD;
      group_blinks = w.error_code;
      blinks_to_go = '0;
      groups_to_go = w.repeat_count;
      stage_left   = ledblk_pkg::LEAD_MS;
      lit          = 1'b0;
    end else if (playing) begin
      if (stage_left > 1) begin
        stage_left--;
      end else begin
        case (stage)
          ST_LEAD: open_group();
          ST_ON: begin
            lit        = 1'b0;
            stage      = ST_OFF;
            stage_left = ledblk_pkg::BLINK_MS;
          end
          ST_OFF: begin
            if (blinks_to_go != 0) blinks_to_go--;
            if (blinks_to_go != 0) begin
              lit        = 1'b1;
              stage      = ST_ON;
              stage_left = ledblk_pkg::BLINK_MS;
            end else begin
              stage      = ST_GAP;
              stage_left = ledblk_pkg::GAP_MS;
            end
          end
          default: begin
            if (groups_to_go != 0) groups_to_go--;
            open_group();
          end
        endcase
      end
    end else if (phase_left <= 1) begin
      // Switch phase; duty above full counts as full
      pct  = 32'((regs.duty > ledblk_pkg::DUTY_FULL) ? ledblk_pkg::DUTY_FULL : regs.duty);
      span = 32'(regs.cycle);
      if (!lit) begin
        if (regs.identify) begin
          lit = 1'b1;
          len = 32'(ledblk_pkg::IDENT_MS);
        end else if (pct == 0) begin
          len = span;
        end else begin
          lit = 1'b1;
          len = (pct >= ledblk_pkg::DUTY_FULL) ? span : span * pct / ledblk_pkg::DUTY_FULL;
        end
      end else begin
        if (regs.identify) begin
          lit = 1'b0;
          len = 32'(ledblk_pkg::IDENT_MS);
        end else if (pct >= ledblk_pkg::DUTY_FULL) begin
          len = span;
        end else begin
          lit = 1'b0;
          len = span * (ledblk_pkg::DUTY_FULL - pct) / ledblk_pkg::DUTY_FULL;
        end
      end
      // Hold a too-short phase for one tick
      if (len == 0) len = 1;
      phase_left = len[15:0];
    end else begin
      phase_left--;
    end
    r.led_on    = lit;
    r.code_busy = playing;
    return r;
  endfunction

  // Watch all three channels: compare results first, then track writes, then predict
  always @(posedge clk) begin
    if (!rst_n) begin
      regs.duty     = ledblk_pkg::DUTY_RST;
      regs.cycle    = ledblk_pkg::CYCLE_RST;
      regs.identify = 1'b0;
      lit           = 1'b0;
      phase_left    = '0;
      playing       = 1'b0;
      stage         = ST_LEAD;
      group_blinks  = '0;
      blinks_to_go  = '0;
      groups_to_go  = '0;
      stage_left    = '0;
      expected_led_q.delete();
      open_words <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        words_out++;
        if (expected_led_q.size() == 0) begin
          report($sformatf("result word %0d arrived with nothing expected", words_out));
        end else begin
          want = expected_led_q.pop_front();
          if (out_led_on !== want.led_on)
            report($sformatf("word %0d led_on %b, expected %b",
                             words_out, out_led_on, want.led_on));
          if (out_code_busy !== want.code_busy)
            report($sformatf("word %0d code_busy %b, expected %b",
                             words_out, out_code_busy, want.code_busy));
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ledblk_pkg::REG_DUTY:     regs.duty     = cfg_wdata[6:0];
          ledblk_pkg::REG_CYCLE:    regs.cycle    = cfg_wdata;
          ledblk_pkg::REG_IDENTIFY: regs.identify = cfg_wdata[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        seen.action       = in_action;
        seen.error_code   = in_error_code;
        seen.repeat_count = in_repeat_count;
        expected_led_q.push_back(predict_led(seen));
      end
      open_words <= expected_led_q.size();
    end
  end

endmodule

@@ tb/tb_led_duty_and_error_code_blinker.sv @@
// Top of the LED blinker testbench: clock, reset, stimulus, stalls and the verdict.
`timescale 1ns / 1ps

module tb_led_duty_and_error_code_blinker;

  localparam int SETTLE       = 8;
  localparam int RANDOM_WORDS = 300;
  localparam int HOLD_CYCLES  = 64;
  localparam int CYCLE_LIMIT  = 300000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_action = 1'b0;
  logic [3:0]  in_error_code = '0;
  logic [7:0]  in_repeat_count = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        out_led_on;
  logic        out_code_busy;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  int   open_words;
  int   mismatches;
  int   sent_words = 0;
  int   cycle_count = 0;
  logic calm = 1'b0;
  logic hold_on = 1'b0;
  int   burst_left = 0;

  always #1 clk = ~clk;

  led_duty_and_error_code_blinker dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_error_code   (in_error_code),
    .in_repeat_count (in_repeat_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_on      (out_led_on),
    .out_code_busy   (out_code_busy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  ledblk_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_error_code   (in_error_code),
    .in_repeat_count (in_repeat_count),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_led_on      (out_led_on),
    .out_code_busy   (out_code_busy),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .open_words      (open_words),
    .mismatches      (mismatches)
  );

  // Stall the result side in random bursts, or solid during the hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      burst_left <= 0;
    end else if (hold_on) begin
      out_stall <= 1'b1;
    end else if (burst_left != 0) begin
      out_stall  <= 1'b1;
      burst_left <= burst_left - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_stall  <= 1'b1;
      burst_left <= $urandom_range(0, 4);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Hold off the receiver once for a long stretch so the block backs up
  initial begin
    wait (sent_words >= 200);
    @(posedge clk);
    hold_on <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on <= 1'b0;
  end

  // End the run if it takes far longer than it should
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_led_duty_and_error_code_blinker NOT OK");
    $finish;
  end

  // Offer one input word, idling first at random, and wait until it is taken
  task automatic put_word(input ledblk_tb_pkg::action_e act, input logic [3:0] code,
                          input logic [7:0] rep);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_action       <= act;
    in_error_code   <= code;
    in_repeat_count <= rep;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_words++;
  endtask

  // Send a millisecond tick with junk in the unused fields
  task automatic tick();
    put_word(ledblk_tb_pkg::ACT_TICK, 4'($urandom), 8'($urandom));
  endtask

  // Drop valid and wait until every expected word has come back, then settle
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (open_words != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write one register; valid stays up so writes can go back to back
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Load all three registers while the block is idle
  task automatic set_regs(input logic [6:0] duty, input logic [15:0] span, input logic ident);
    drain();
    write_reg(ledblk_pkg::REG_DUTY, {9'd0, duty});
    write_reg(ledblk_pkg::REG_CYCLE, span);
    write_reg(ledblk_pkg::REG_IDENTIFY, {15'd0, ident});
    cfg_valid <= 1'b0;
  endtask

  initial begin
    int          base;
    int          burst;
    logic [6:0]  duty;
    logic [15:0] span;
    logic [3:0]  code;
    logic [7:0]  rep;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: first tick lights the LED, then start and restart a code
    repeat (3) tick();
    put_word(ledblk_tb_pkg::ACT_START, 4'hF, 8'hFF);
    tick();
    put_word(ledblk_tb_pkg::ACT_START, 4'h0, 8'h00);
    repeat (2) tick();

    // Zero duty, then full duty with a zero cycle, both in the lead pause: LED dark
    set_regs(7'd0, 16'd1, 1'b0);
    repeat (3) tick();
    set_regs(ledblk_pkg::DUTY_FULL, 16'd0, 1'b0);
    repeat (3) tick();
    // Duty above full, longest cycle
    set_regs(7'd127, 16'hFFFF, 1'b0);
    repeat (2) tick();
    // Duty and cycle whose product rounds down to zero, set during the lead pause
    set_regs(7'd1, 16'd1, 1'b0);
    repeat (3) tick();
    set_regs(7'd50, 16'd200, 1'b1);
    repeat (3) tick();

    // Random phases: new settings, then a run of ticks or a code sequence
    base = sent_words;
    while (sent_words - base < RANDOM_WORDS) begin
      calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       duty = 7'd0;
        1:       duty = ledblk_pkg::DUTY_FULL;
        2:       duty = 7'($urandom_range(101, 127));
        default: duty = 7'($urandom_range(1, 99));
      endcase
      case ($urandom_range(0, 7))
        0:       span = 16'd0;
        1:       span = 16'd1;
        2:       span = 16'hFFFF;
        3:       span = 16'($urandom);
        default: span = 16'($urandom_range(2, 40));
      endcase
      set_regs(duty, span, $urandom_range(0, 4) == 0);
      if ($urandom_range(0, 1) == 0) begin
        repeat ($urandom_range(40, 250)) tick();
      end else begin
        code = 4'($urandom);
        rep  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 2));
        put_word(ledblk_tb_pkg::ACT_START, code, rep);
        // Run a zero-repeat sequence near or past the end of its lead pause so normal blinking can resume
        burst = (rep == 0) ? $urandom_range(480, 700) : $urandom_range(100, 900);
        repeat (burst) begin
          if ($urandom_range(0, 249) == 0) begin
            put_word(ledblk_tb_pkg::ACT_START, 4'($urandom), 8'($urandom));
          end else begin
            tick();
          end
        end
      end
    end

    // Last part, no idling: one bare-gap group and then the end of sequence
    calm = 1'b1;
    set_regs(7'd30, 16'd20, 1'b0);
    put_word(ledblk_tb_pkg::ACT_START, 4'd0, 8'd1);
    repeat (2510) tick();
    drain();

    if (mismatches == 0) begin
      $display("tb_led_duty_and_error_code_blinker OK");
    end else begin
      $display("tb_led_duty_and_error_code_blinker NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/ledblk_pkg.sv
src/ledblk_len_calc.sv
src/ledblk_core.sv
src/led_duty_and_error_code_blinker.sv
tb/ledblk_checker.sv
tb/tb_led_duty_and_error_code_blinker.sv
